>>> sv/hcmb_pkg.sv
// Shared types, command codes, state encoding and address decode for the console bus.
`default_nettype none
package hcmb_pkg;

  localparam logic [2:0] CMD_RD_BYTE = 3'd0;
  localparam logic [2:0] CMD_RD_WORD = 3'd1;
  localparam logic [2:0] CMD_WR_BYTE = 3'd2;
  localparam logic [2:0] CMD_WR_WORD = 3'd3;
  localparam logic [2:0] CMD_LOAD    = 3'd4;

  localparam logic [15:0] ROM_LAST   = 16'h7FFF;
  localparam logic [15:0] ECHO_FIRST = 16'hE000;
  localparam logic [15:0] ECHO_LAST  = 16'hFDFF;
  localparam logic [15:0] ECHO_SHIFT = 16'h2000;
  localparam logic [15:0] IO_FIRST   = 16'hFF00;
  localparam logic [15:0] IO_LAST    = 16'hFF7F;
  localparam logic [15:0] ADDR_NONE  = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        go;
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } acc_t;

  localparam logic [7:0] IO_RESET [128] = '{
    8'h0F, 8'h00, 8'h7C, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hF8,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01,
    8'h80, 8'hBF, 8'hF3, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00,
    8'hFF, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF,
    8'hFF, 8'h00, 8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
    8'h91, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC,
    8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h7E, 8'hFF, 8'hFE,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h3E, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hC0, 8'hFF, 8'hC1, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hFF,
    8'hF8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h8F, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  function automatic logic is_word(input logic [2:0] cmd);
    return (cmd == CMD_RD_WORD) || (cmd == CMD_WR_WORD);
  endfunction

  function automatic logic is_read(input logic [2:0] cmd);
    return (cmd == CMD_RD_BYTE) || (cmd == CMD_RD_WORD);
  endfunction

  function automatic logic is_write(input logic [2:0] cmd);
    return (cmd == CMD_WR_BYTE) || (cmd == CMD_WR_WORD);
  endfunction

  // fold the echo window onto work RAM
  function automatic logic [15:0] phys_index(input logic [15:0] addr);
    if ((addr >= ECHO_FIRST) && (addr <= ECHO_LAST)) begin
      return addr - ECHO_SHIFT;
    end
    return addr;
  endfunction

  function automatic logic is_io(input logic [15:0] addr);
    return (addr >= IO_FIRST) && (addr <= IO_LAST);
  endfunction

endpackage
`default_nettype wire

>>> sv/hcmb_mem.sv
// Unified byte memory of the bus with I/O reset defaults and registered read byte.
`default_nettype none
module hcmb_mem (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire hcmb_pkg::acc_t acc,
  output logic [7:0]        rd_byte
);

  logic [7:0]   mem [65536];
  logic [127:0] io_valid_r;
  logic [7:0]   mem_q_r;
  logic         tag_zero_r;
  logic         tag_iodef_r;
  logic [6:0]   tag_io_idx_r;

  logic         rd_go;
  logic         wr_go;
  logic [15:0]  idx;
  logic         io_hit;

  always_comb begin
    io_hit = hcmb_pkg::is_io(acc.addr);
    rd_go  = acc.go && hcmb_pkg::is_read(acc.cmd);
    wr_go  = 1'b0;
    idx    = hcmb_pkg::phys_index(acc.addr);
    if (acc.go && hcmb_pkg::is_write(acc.cmd)) begin
      wr_go = (acc.addr > hcmb_pkg::ROM_LAST) && (acc.addr != hcmb_pkg::ADDR_NONE);
    end else if (acc.go && (acc.cmd == hcmb_pkg::CMD_LOAD)) begin
      wr_go = (acc.addr <= hcmb_pkg::ROM_LAST);
      idx   = acc.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[idx] <= acc.wdata;
    end
    if (rd_go) begin
      mem_q_r <= mem[idx];
    end
    if (acc.go) begin
      tag_zero_r   <= !rd_go || (acc.addr == hcmb_pkg::ADDR_NONE);
      tag_iodef_r  <= io_hit && !io_valid_r[acc.addr[6:0]];
      tag_io_idx_r <= acc.addr[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_valid_r <= '0;
    end else if (wr_go && io_hit) begin
      io_valid_r[acc.addr[6:0]] <= 1'b1;
    end
  end

  always_comb begin
    if (tag_zero_r) begin
      rd_byte = 8'h00;
    end else if (tag_iodef_r) begin
      rd_byte = hcmb_pkg::IO_RESET[tag_io_idx_r];
    end else begin
      rd_byte = mem_q_r;
    end
  end

endmodule
`default_nettype wire

>>> sv/handheld_console_memory_bus.sv
// Top level of the console memory bus: command sequencing and result register.
//
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   in_command, in_address, in_write_data
// out_     output     out_valid / out_stall out_read_data
//
// Byte commands, loads and unused codes go straight to ST_FIN; word commands first pass ST_HI,
// since the single memory port serves one byte per cycle.
// Reads pass mem_q_r, then out_data_r; the next item is taken as the result is registered.
// Reset clears the sequencer, the result valid and the I/O written flags (no memory sweep).
// A stalled result holds the block once the following item has finished.
`default_nettype none
module handheld_console_memory_bus (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_data
);

  hcmb_pkg::state_t state_r, state_nxt;
  logic [2:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  data_hi_r;
  logic        word_r;
  logic [7:0]  lo_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;

  logic           out_free;
  logic           out_load;
  logic           hi_go;
  logic           accept;
  hcmb_pkg::acc_t acc;
  logic [7:0]     rd_byte;

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    hi_go    = 1'b0;
    unique case (state_r)
      hcmb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      hcmb_pkg::ST_HI: begin
        hi_go = 1'b1;
      end
      hcmb_pkg::ST_FIN: begin
        out_load = out_free;
        in_stall = !out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hcmb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = hcmb_pkg::is_word(in_command) ? hcmb_pkg::ST_HI : hcmb_pkg::ST_FIN;
        end
      end
      hcmb_pkg::ST_HI: begin
        state_nxt = hcmb_pkg::ST_FIN;
      end
      hcmb_pkg::ST_FIN: begin
        if (accept) begin
          state_nxt = hcmb_pkg::is_word(in_command) ? hcmb_pkg::ST_HI : hcmb_pkg::ST_FIN;
        end else if (out_load) begin
          state_nxt = hcmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hcmb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (hi_go) begin
      acc.go    = 1'b1;
      acc.cmd   = cmd_r;
      acc.addr  = addr_r + 16'd1;
      acc.wdata = data_hi_r;
    end else begin
      acc.go    = accept;
      acc.cmd   = in_command;
      acc.addr  = in_address;
      acc.wdata = in_write_data[7:0];
    end
  end

  hcmb_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rd_byte (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcmb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_command;
      addr_r    <= in_address;
      data_hi_r <= in_write_data[15:8];
      word_r    <= hcmb_pkg::is_word(in_command);
    end
    if (hi_go) begin
      lo_r <= rd_byte;
    end
    if (out_load) begin
      out_data_r <= word_r ? {rd_byte, lo_r} : {8'h00, rd_byte};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
`default_nettype wire
